FILE: rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock while out of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every clock, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: rtl/wtss_pkg.sv
// Shared types and constants of the wave terrain spline sampler.
`default_nettype none
package wtss_pkg;

    // Table geometry
    localparam int TABLE_ROWS = 8;
    localparam int ROW_LENGTH = 1024;
    localparam int ROW_W      = 3;
    localparam int COL_W      = 10;
    localparam int ADDR_W     = ROW_W + COL_W;
    localparam int DEPTH      = TABLE_ROWS * ROW_LENGTH;
    localparam int WORD_W     = 16;

    // Sample datapath
    localparam int FOLD_W   = 15;
    localparam int PF_W     = 16;
    localparam int MF_W     = 16;
    localparam int TAPS     = 6;
    localparam int S_CNT    = 2 * TAPS;
    localparam int READS    = 2 * S_CNT;
    localparam int TAG_W    = 5;
    localparam int ACC_W    = 32;
    localparam int PROD_W   = 53;
    localparam int OUT_W    = 12;
    localparam int LANE_STG = 12;
    localparam logic signed [21:0] SPLINE_SCALE = 22'sd699051;

    // Command and mode codes
    localparam logic CMD_WRITE    = 1'b0;
    localparam logic CMD_SAMPLE   = 1'b1;
    localparam logic MODE_PRODUCT = 1'b0;
    localparam logic MODE_SUM     = 1'b1;

    typedef logic signed [WORD_W-1:0] word_t;

    // Per-read side info carried along the fetch pipe
    typedef struct packed {
        logic [MF_W-1:0] mf;
        logic [PF_W-1:0] pfx;
        logic [PF_W-1:0] pfy;
    } meta_t;

    // Handoff from fetch/blend to the spline lanes
    typedef struct packed {
        logic            vld;
        logic [PF_W-1:0] pfx;
        logic [PF_W-1:0] pfy;
    } blend_ctl_t;

    // One spline lane pipeline stage
    typedef struct packed {
        logic                     vld;
        logic [PF_W-1:0]          pf;
        logic signed [ACC_W-1:0]  acc;
        logic signed [PROD_W-1:0] prod;
        logic [0:3][ACC_W-1:0]    lin;
        word_t                    s2;
    } lane_t;

    // Mirror fold of position plus offset into 0..32767
    function automatic logic [FOLD_W-1:0] fold(input logic signed [19:0] p,
                                               input logic signed [19:0] off);
        logic signed [20:0] sum;
        logic [20:0]        mag;
        sum = 21'(p) + 21'(off);
        mag = sum[20] ? 21'(-sum) : 21'(sum);
        return mag[FOLD_W] ? ~mag[FOLD_W-1:0] : mag[FOLD_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: rtl/wave_terrain_spline_sampler.sv
// Top level of the wave terrain spline sampler.
// A sample beat holds the input while its reads are issued: each one needs 24 reads
// (two rows by six columns for each of two axes) from the single-port table RAM, one
// per cycle while the pipe is not stalled, and that port sets the rate. The result
// beat follows the last read through the row blend, the spline lanes and the output
// register; the blend and spline datapath is a stall-together pipeline that moves only
// while the output register is free or taken. The table is not cleared at reset;
// every entry a sample reads must be written first. The user must write combine_mode
// through cfg_we/cfg_wdata only while the block is idle; the block does not enforce it.
`default_nettype none
module wave_terrain_spline_sampler import wtss_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic         cfg_wdata,     // combine_mode
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic         s_tuser,       // command
    // x_position[19:0], y_position[39:20], shared_offset[59:40], morph_position[74:60],
    // write_row[77:75], write_column[87:78], write_value[103:88]
    input  wire logic [103:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [15:0]       m_tdata        // terrain_sample[11:0], zero above
);

    logic              mode_reg;
    logic              en;
    blend_ctl_t        ctl;
    word_t [S_CNT-1:0] s_vals;
    logic              xv, yv;
    logic [FOLD_W-1:0] xs, ys;

    // Pipe advances while the output register is empty or being taken
    assign en = !m_tvalid || m_tready;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_PRODUCT;
        end else if (cfg_we) begin
            mode_reg <= cfg_wdata;
        end
    end

    wtss_fetch u_fetch (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .ctl      (ctl),
        .s_vals   (s_vals)
    );

    wtss_spline u_lane_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (ctl.vld),
        .pf      (ctl.pfx),
        .s       (s_vals[TAPS-1:0]),
        .out_vld (xv),
        .out_val (xs)
    );

    wtss_spline u_lane_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (ctl.vld),
        .pf      (ctl.pfy),
        .s       (s_vals[S_CNT-1:TAPS]),
        .out_vld (yv),
        .out_val (ys)
    );

    // Combine the two axes into the output register
    logic [2*FOLD_W-1:0] prod;
    logic [FOLD_W:0]     sum;
    logic [OUT_W-1:0]    res;
    logic                vld_reg;
    logic [OUT_W-1:0]    data_reg;

    assign prod = (2*FOLD_W)'(xs) * (2*FOLD_W)'(ys);
    assign sum  = (FOLD_W+1)'(xs) + (FOLD_W+1)'(ys);

    always_comb begin
        unique case (mode_reg)
            MODE_SUM: res = OUT_W'(sum >> 4);
            default:  res = OUT_W'(prod >> 18);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= xv && yv;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= res;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = {(16 - OUT_W)'(0), data_reg};

endmodule
`default_nettype wire

FILE: rtl/wtss_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module wtss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

FILE: rtl/wtss_fetch.sv
// Table read sequencer and row blend: 24 reads per sample into 12 blended taps.
`default_nettype none
module wtss_fetch import wtss_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        en,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic        s_tuser,
    input  wire logic [103:0] s_tdata,
    output blend_ctl_t       ctl,
    output word_t [S_CNT-1:0] s_vals
);

    // Input beat fields
    logic signed [19:0] x_pos, y_pos, offs;
    logic [14:0]        morph;
    logic [ROW_W-1:0]   wr_row;
    logic [COL_W-1:0]   wr_col;
    logic [WORD_W-1:0]  wr_val;

    assign x_pos  = s_tdata[19:0];
    assign y_pos  = s_tdata[39:20];
    assign offs   = s_tdata[59:40];
    assign morph  = s_tdata[74:60];
    assign wr_row = s_tdata[77:75];
    assign wr_col = s_tdata[87:78];
    assign wr_val = s_tdata[103:88];

    // Sequencer state
    logic             busy_reg;
    logic [TAG_W-1:0] cnt_reg;
    logic [8:0]       colx_reg, coly_reg;
    logic [1:0]       row_reg;
    meta_t            meta_reg;

    logic [FOLD_W-1:0] fx, fy;
    meta_t             meta_in, meta_iss;
    logic [8:0]        colx, coly, col_sel;
    logic [1:0]        row_base;
    logic [TAG_W-1:0]  idx;
    logic              axis;
    logic [3:0]        j;
    logic              start, iss, wr;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] rdata;

    assign fx          = fold(x_pos, offs);
    assign fy          = fold(y_pos, offs);
    assign meta_in.mf  = {morph[12:3], 6'b0};
    assign meta_in.pfx = {fx[5:0], 10'b0};
    assign meta_in.pfy = {fy[5:0], 10'b0};

    assign s_tready = en && !busy_reg;
    assign start    = s_tvalid && s_tready && (s_tuser == CMD_SAMPLE);
    assign wr       = s_tvalid && s_tready && (s_tuser == CMD_WRITE);
    assign iss      = start || (en && busy_reg);

    // Read address: first read straight from the beat, the rest from registers
    assign idx      = busy_reg ? cnt_reg : '0;
    assign colx     = busy_reg ? colx_reg : fx[14:6];
    assign coly     = busy_reg ? coly_reg : fy[14:6];
    assign row_base = busy_reg ? row_reg : morph[14:13];
    assign meta_iss = busy_reg ? meta_reg : meta_in;
    assign axis     = (idx >= TAG_W'(S_CNT));
    assign j        = axis ? 4'(idx - TAG_W'(S_CNT)) : idx[3:0];
    assign col_sel  = axis ? coly : colx;

    always_comb begin
        if (wr) begin
            addr = {wr_row, wr_col};
        end else begin
            addr = {ROW_W'(row_base) + ROW_W'(j[0]), COL_W'(col_sel) + COL_W'(j[3:1])};
        end
    end

    wtss_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (wr),
        .re    (iss),
        .addr  (addr),
        .wdata (wr_val),
        .rdata (rdata)
    );

    // Sequencer control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= TAG_W'(1);
        end else if (en && busy_reg) begin
            cnt_reg <= cnt_reg + TAG_W'(1);
            if (cnt_reg == TAG_W'(READS - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            colx_reg <= fx[14:6];
            coly_reg <= fy[14:6];
            row_reg  <= morph[14:13];
            meta_reg <= meta_in;
        end
    end

    // P1: read in flight
    logic             rd_vld_reg;
    logic [TAG_W-1:0] rd_tag_reg;
    meta_t            rd_meta_reg;
    // P2: row pair difference
    word_t            a_reg;
    logic             bl_vld_reg;
    logic signed [WORD_W:0] diff_reg;
    word_t            bl_base_reg;
    logic [TAG_W-1:0] bl_tag_reg;
    meta_t            bl_meta_reg;
    // P3: blend product
    logic             mu_vld_reg;
    logic signed [2*WORD_W+1:0] mu_prod_reg;
    word_t            mu_base_reg;
    logic [TAG_W-1:0] mu_tag_reg;
    meta_t            mu_meta_reg;
    // P4: tap store
    word_t [S_CNT-1:0] s_reg;
    logic              done_vld_reg;
    logic [PF_W-1:0]   pfx_reg, pfy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg   <= 1'b0;
            bl_vld_reg   <= 1'b0;
            mu_vld_reg   <= 1'b0;
            done_vld_reg <= 1'b0;
        end else if (en) begin
            rd_vld_reg   <= iss;
            bl_vld_reg   <= rd_vld_reg && rd_tag_reg[0];
            mu_vld_reg   <= bl_vld_reg;
            done_vld_reg <= mu_vld_reg && (mu_tag_reg == TAG_W'(READS - 1));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rd_tag_reg  <= idx;
            rd_meta_reg <= meta_iss;
            if (rd_vld_reg && !rd_tag_reg[0]) begin
                a_reg <= rdata;
            end
            diff_reg    <= $signed({rdata[WORD_W-1], rdata}) - $signed({a_reg[WORD_W-1], a_reg});
            bl_base_reg <= a_reg;
            bl_tag_reg  <= rd_tag_reg;
            bl_meta_reg <= rd_meta_reg;
            mu_prod_reg <= (2*WORD_W+2)'(diff_reg * $signed({1'b0, bl_meta_reg.mf}));
            mu_base_reg <= bl_base_reg;
            mu_tag_reg  <= bl_tag_reg;
            mu_meta_reg <= bl_meta_reg;
            if (mu_vld_reg) begin
                s_reg[mu_tag_reg[4:1]] <= mu_base_reg + WORD_W'(mu_prod_reg >>> 16);
            end
            if (mu_vld_reg && (mu_tag_reg == TAG_W'(READS - 1))) begin
                pfx_reg <= mu_meta_reg.pfx;
                pfy_reg <= mu_meta_reg.pfy;
            end
        end
    end

    assign ctl.vld = done_vld_reg;
    assign ctl.pfx = pfx_reg;
    assign ctl.pfy = pfy_reg;
    assign s_vals  = s_reg;

endmodule
`default_nettype wire

FILE: rtl/wtss_spline.sv
// One axis quintic spline lane: Horner steps alternating multiply and add stages.
`default_nettype none
module wtss_spline import wtss_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic             in_vld,
    input  wire logic [PF_W-1:0]  pf,
    input  word_t [TAPS-1:0]      s,
    output logic                  out_vld,
    output logic [FOLD_W-1:0]     out_val
);

    logic signed [ACC_W-1:0] e [TAPS];
    lane_t                   stg_next [LANE_STG];
    lane_t                   stg_reg [LANE_STG];

    // Sign-extend taps
    always_comb begin
        for (int k = 0; k < TAPS; k++) begin
            e[k] = ACC_W'(s[k]);
        end
    end

    // Stage 0: leading coefficient and the lower-order polynomial coefficients
    always_comb begin
        stg_next[0].vld    = in_vld;
        stg_next[0].pf     = pf;
        stg_next[0].prod   = '0;
        stg_next[0].s2     = s[2];
        stg_next[0].acc    = (e[3] - e[2]) * 32'sd50 + (e[1] - e[4]) * 32'sd25
                           + (e[5] - e[0]) * 32'sd5;
        stg_next[0].lin[0] = e[2] * 32'sd126 - e[3] * 32'sd124 + e[4] * 32'sd61
                           - e[1] * 32'sd64 - e[5] * 32'sd12 + e[0] * 32'sd13;
        stg_next[0].lin[1] = e[3] * 32'sd66 - e[2] * 32'sd70 - e[4] * 32'sd33
                           + e[1] * 32'sd39 + e[5] * 32'sd7 - e[0] * 32'sd9;
        stg_next[0].lin[2] = (e[3] + e[1]) * 32'sd16 - e[0] - e[2] * 32'sd30 - e[4];
        stg_next[0].lin[3] = (e[3] - e[1]) * 32'sd16 + (e[0] - e[4]) * 32'sd2;
    end

    // Five rounds of acc = lin + floor(pf * acc / 2^16), the last one without lin
    for (genvar i = 1; i < LANE_STG - 1; i++) begin : g_horner
        if (i % 2 == 1) begin : g_mul
            always_comb begin
                stg_next[i]      = stg_reg[i-1];
                stg_next[i].prod = PROD_W'($signed({1'b0, stg_reg[i-1].pf})
                                            * stg_reg[i-1].acc);
            end
        end else if (i < LANE_STG - 2) begin : g_add
            always_comb begin
                stg_next[i]     = stg_reg[i-1];
                stg_next[i].acc = $signed(stg_reg[i-1].lin[(i/2)-1])
                                + ACC_W'(stg_reg[i-1].prod >>> 16);
            end
        end else begin : g_last
            always_comb begin
                stg_next[i]     = stg_reg[i-1];
                stg_next[i].acc = ACC_W'(stg_reg[i-1].prod >>> 16);
            end
        end
    end

    // Scale by about 1/24
    always_comb begin
        stg_next[LANE_STG-1]      = stg_reg[LANE_STG-2];
        stg_next[LANE_STG-1].prod = PROD_W'(SPLINE_SCALE * stg_reg[LANE_STG-2].acc);
    end

    // Stage registers
    for (genvar i = 0; i < LANE_STG; i++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                stg_reg[i].vld <= 1'b0;
            end else if (en) begin
                stg_reg[i] <= stg_next[i];
            end
        end
    end

    // Offset by the center tap and clamp to 15 bits
    logic signed [ACC_W:0] sum;
    logic [FOLD_W-1:0]     clamp;
    logic                  vld_reg;
    logic [FOLD_W-1:0]     val_reg;

    assign sum = (ACC_W+1)'(stg_reg[LANE_STG-1].s2)
               + (ACC_W+1)'(stg_reg[LANE_STG-1].prod >>> 24);

    always_comb begin
        priority if (sum < 0) begin
            clamp = '0;
        end else if (sum > (ACC_W+1)'(32767)) begin
            clamp = '1;
        end else begin
            clamp = sum[FOLD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= stg_reg[LANE_STG-1].vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            val_reg <= clamp;
        end
    end

    assign out_vld = vld_reg;
    assign out_val = val_reg;

endmodule
`default_nettype wire

FILE: rtl/wtss_checker.sv
// Port-level checker for the wave terrain spline sampler, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module wtss_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         s_tuser,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [15:0]  m_tdata
);

    // Stalled result beat stays up
    `ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "m_tvalid dropped while stalled")
    // Stalled result beat keeps its data
    `ASSERT_CLK(a_out_stable, m_tvalid && !m_tready |=> $stable(m_tdata), "m_tdata changed while stalled")
    // A sample beat occupies the table port for the following cycles
    `ASSERT_CLK(a_sample_busy, s_tvalid && s_tready && s_tuser |=> !s_tready, "input ready right after a sample beat")
    // No result straight out of reset
    `ASSERT_ALWAYS(a_reset_quiet, !aresetn |=> !m_tvalid, "m_tvalid after reset")

endmodule

bind wave_terrain_spline_sampler wtss_checker u_wtss_checker (.*);
`default_nettype wire

FILE: verif/wave_terrain_spline_checker.sv
// Checker for the wave terrain spline sampler: predicts each sample and compares results.
module wave_terrain_spline_checker import wtss_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic         cfg_wdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic         s_tuser,
    input  logic [103:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [15:0]  m_tdata,
    output int           errors,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SCALE = 699051;

    logic signed [15:0] terrain_table [0:DEPTH-1];
    logic               mode_q;
    logic [15:0]        sample_queue [$];

    // Mirror fold of (position + offset) into 0..32767
    function automatic logic [14:0] mirror_fold(logic signed [19:0] p,
                                                logic signed [19:0] off);
        longint sum;
        longint mag;
        sum = longint'(p) + longint'(off);
        mag = (sum < 0) ? -sum : sum;
        if (mag[15])
            return 15'(32767 - (mag & 32767));
        return 15'(mag & 32767);
    endfunction

    // Row blend, quintic spline and clamp for one axis
    function automatic longint axis_spline(logic [14:0] f, logic [11:0] m);
        longint tap [6];
        longint lo;
        longint hi;
        longint pf;
        longint mf;
        longint t;
        longint res;
        int     col;
        int     row;
        col = int'(f) >> 6;
        pf  = longint'(f & 15'h3F) << 10;
        row = int'(m) >> 10;
        mf  = longint'(m & 12'h3FF) << 6;
        for (int k = 0; k < 6; k++) begin
            lo = terrain_table[row * ROW_LENGTH + col + k];
            hi = terrain_table[(row + 1) * ROW_LENGTH + col + k];
            tap[k] = lo + (((hi - lo) * mf) >>> 16);
        end
        t = (tap[3] - tap[2]) * 50 + (tap[1] - tap[4]) * 25 + (tap[5] - tap[0]) * 5;
        t = tap[2] * 126 - tap[3] * 124 + tap[4] * 61 - tap[1] * 64 - tap[5] * 12
            + tap[0] * 13 + ((pf * t) >>> 16);
        t = tap[3] * 66 - tap[2] * 70 - tap[4] * 33 + tap[1] * 39 + tap[5] * 7
            - tap[0] * 9 + ((pf * t) >>> 16);
        t = (tap[3] + tap[1]) * 16 - tap[0] - tap[2] * 30 - tap[4] + ((pf * t) >>> 16);
        t = (tap[3] - tap[1]) * 16 + (tap[0] - tap[4]) * 2 + ((pf * t) >>> 16);
        t = (pf * t) >>> 16;
        res = tap[2] + ((SCALE * t) >>> 24);
        if (res < 0)
            res = 0;
        if (res > 32767)
            res = 32767;
        return res;
    endfunction

    // Combine the two axes into the 12-bit terrain sample
    function automatic logic [15:0] terrain_sample(logic [103:0] d, logic mode);
        logic [11:0] m;
        longint      xs;
        longint      ys;
        longint      r;
        m  = d[74:63];
        xs = axis_spline(mirror_fold(d[19:0], d[59:40]), m);
        ys = axis_spline(mirror_fold(d[39:20], d[59:40]), m);
        r  = (mode == MODE_SUM) ? ((xs + ys) >>> 4) : ((xs * ys) >>> 18);
        return {4'b0, 12'(r)};
    endfunction

    assign pending = sample_queue.size();

    // Track table and mode, queue predictions, check results
    always @(posedge aclk) begin
        logic [15:0] want;
        if (!aresetn) begin
            mode_q = MODE_PRODUCT;
            sample_queue.delete();
            errors = 0;
        end else begin
            if (cfg_we)
                mode_q = cfg_wdata;
            if (s_tvalid && s_tready) begin
                if (s_tuser == CMD_WRITE)
                    terrain_table[{s_tdata[77:75], s_tdata[87:78]}] = s_tdata[103:88];
                else
                    sample_queue.push_back(terrain_sample(s_tdata, mode_q));
            end
            if (m_tvalid && m_tready) begin
                if (sample_queue.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result beat %h", m_tdata);
                end else begin
                    want = sample_queue.pop_front();
                    if (want !== m_tdata) begin
                        errors++;
                        if (errors <= 10)
                            $display("terrain_sample: expected %h got %h", want, m_tdata);
                    end
                end
            end
        end
    end

    // Leftover predictions are checked by the top after draining
endmodule

FILE: verif/wave_terrain_spline_sampler_tb.sv
// Testbench top of the wave terrain spline sampler: stimulus, idling and verdict.
module wave_terrain_spline_sampler_tb;
    import wtss_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;
    // Written columns: a low band and the top band that the fold edge reaches
    localparam int LOW_COLS = 64;
    localparam int TOP_COL  = 511;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_we = 1'b0;
    logic         cfg_wdata = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic         s_tuser = CMD_WRITE;
    logic [103:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [15:0]  m_tdata;
    int           errors;
    int           pending;
    int           tx_idle_pct = 0;
    int           rx_idle_pct = 0;
    int           quiet_cycles = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    wave_terrain_spline_sampler dut (.*);

    wave_terrain_spline_checker chk (.*);

    // Receiver backpressure
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= rx_idle_pct);

    // Watchdog on cycles with no beat on either channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("wave_terrain_spline_sampler: mismatch");
            $finish;
        end
    end

    task automatic send_beat(logic cmd, logic [103:0] d);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_word(int row, int col, logic [15:0] v);
        send_beat(CMD_WRITE, {v, 10'(col), 3'(row), 75'b0});
    endtask

    task automatic sample(logic [19:0] x, logic [19:0] y, logic [19:0] off,
                          logic [14:0] m);
        send_beat(CMD_SAMPLE, {29'b0, m, off, y, x});
    endtask

    // Folded value landing in a written column band
    function automatic int pick_fold();
        if ($urandom_range(9) == 0)
            return TOP_COL * 64 + int'($urandom_range(63));
        return int'($urandom_range(LOW_COLS * 64 - 1));
    endfunction

    // Position that folds to f with the given offset, random period, mirror and sign
    function automatic logic [19:0] aim_position(int f, int off);
        int mag;
        int p;
        mag = int'($urandom_range(3)) * 65536;
        mag = mag + (($urandom_range(1) == 1) ? (65535 - f) : f);
        p   = ($urandom_range(1) == 1) ? -mag : mag;
        return 20'(p - off);
    endfunction

    // Wait for all results, let the pipe settle, then write the mode
    task automatic drain_and_set(logic mode);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int count);
        int off;
        for (int i = 0; i < count; i++) begin
            off = int'($urandom_range(524287)) - 262144;
            if ($urandom_range(99) < 20)
                write_word($urandom_range(7), $urandom_range(1023), 16'($urandom));
            else
                sample(aim_position(pick_fold(), off), aim_position(pick_fold(), off),
                       20'(off), 15'($urandom));
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        drain_and_set(MODE_PRODUCT);

        // Fill rows 0..4 over both column bands, five columns past each band
        for (int r = 0; r < 5; r++) begin
            for (int c = 0; c < LOW_COLS + 5; c++)
                write_word(r, c, 16'($urandom));
            for (int c = TOP_COL; c < TOP_COL + 6; c++)
                write_word(r, c, 16'($urandom));
        end

        // Directed: full-scale words to force both clamp ends
        for (int c = 0; c < 6; c++) begin
            write_word(0, c, 16'h7FFF);
            write_word(1, c, 16'h8000);
        end
        sample(20'h0, 20'h0, 20'h0, 15'h0);
        sample(20'h0, 20'h0, 20'h0, 15'h3FF8);
        sample(20'h7FFFF, 20'h80000, 20'h0, 15'h7FFF);
        sample(20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 15'h0);
        sample(20'h80000, 20'h80000, 20'h80000, 15'h7FFF);
        // Fold edges: 32767, 32768, -32768, 65535
        sample(20'd32767, 20'd32768, 20'h0, 15'd1234);
        sample(-20'sd32768, 20'd65535, 20'h0, 15'd20000);
        sample(20'd1, -20'sd1, 20'd32767, 15'd4095);

        drain_and_set(MODE_SUM);
        sample(20'h0, 20'h0, 20'h0, 15'h0);
        sample(20'h7FFFF, 20'h80000, 20'h7FFFF, 15'h7FFF);
        sample(20'd32767, 20'd65536, 20'h0, 15'd8191);

        // Random phases: sender light / receiver heavy, then swapped, then none
        tx_idle_pct = 6;
        rx_idle_pct = 81;
        random_phase(225);
        drain_and_set(MODE_PRODUCT);
        tx_idle_pct = 81;
        rx_idle_pct = 6;
        random_phase(225);
        drain_and_set(MODE_SUM);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_phase(225);
        drain_and_set(MODE_PRODUCT);
        random_phase(225);

        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (errors == 0 && pending == 0)
            $display("wave_terrain_spline_sampler: match");
        else
            $display("wave_terrain_spline_sampler: mismatch");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/wtss_pkg.sv
rtl/wtss_ram.sv
rtl/wtss_fetch.sv
rtl/wtss_spline.sv
rtl/wave_terrain_spline_sampler.sv
rtl/wtss_checker.sv
verif/wave_terrain_spline_checker.sv
verif/wave_terrain_spline_sampler_tb.sv
